// File: src/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned MAX_PAYLOAD_W = 24;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 24'd1048576;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NOT_FINAL  = 2'd0;
  localparam logic [1:0] ERR_NOT_MASKED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd2;

  localparam logic [0:0] REG_MAX_PAYLOAD = 1'd0;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       last;
    logic [1:0] error_code;
  } res_t;

endpackage

// File: src/websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Parses masked client-to-server WebSocket frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries one stream byte per item.
//   Result channel (out_valid/out_ready/out_*) carries unmasked payload bytes,
//   an empty-frame marker, or one error item.
//   The APB port holds max_payload at byte address 0.
// Throughput: one byte per cycle while the result channel is not stalled;
//   header, extended length and mask key bytes are consumed without a result.
// Data path: each accepted byte passes the input register, then parser logic
//   into the result register.
// Reset: clears the parser to the first header byte and max_payload to
//   1048576. After an error item all bytes are accepted and dropped until reset.
// Stall: while out_ready is low the result register holds; the input register
//   holds one more byte, then in_ready drops.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
  parameter int unsigned LENGTH_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_last,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                              in_valid_r, in_valid_nxt;
  logic [7:0]                        in_byte_r;
  logic                              can_load;
  logic                              fire;
  logic [wsd_pkg::MAX_PAYLOAD_W-1:0] max_payload;
  wsd_pkg::res_t                     res;

  assign fire     = in_valid_r && can_load;
  assign in_ready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r && !fire;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  wsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  wsd_parser #(
    .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (fire),
    .byte_in     (in_byte_r),
    .max_payload (max_payload),
    .res         (res)
  );

  wsd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (fire),
    .res              (res),
    .out_ready        (out_ready),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_last         (out_last),
    .out_error_code   (out_error_code)
  );

endmodule

// File: src/wsd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_cfg_regs
// APB register file: holds the maximum accepted payload length.
// ----------------------------------------------------------------------------
module wsd_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output logic [wsd_pkg::MAX_PAYLOAD_W-1:0]    max_payload
);

  logic [wsd_pkg::MAX_PAYLOAD_W-1:0] max_payload_r;
  logic                              hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2:2] == wsd_pkg::REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsd_pkg::MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && hit) begin
      max_payload_r <= pwdata[wsd_pkg::MAX_PAYLOAD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = 32'(max_payload_r);
    end
  end

  assign max_payload = max_payload_r;

endmodule

// File: src/wsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header / mask / payload state machine; one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int unsigned LENGTH_COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [7:0]                        byte_in,
  input  logic [wsd_pkg::MAX_PAYLOAD_W-1:0] max_payload,
  output wsd_pkg::res_t                     res
);

  localparam int unsigned LCB = LENGTH_COUNT_BITS;
  localparam int unsigned CW  = (LCB > wsd_pkg::MAX_PAYLOAD_W) ? LCB : wsd_pkg::MAX_PAYLOAD_W;

  localparam logic [2:0] PH_HDR0       = 3'd0;
  localparam logic [2:0] PH_HDR1       = 3'd1;
  localparam logic [2:0] PH_HDR1_NOFIN = 3'd2;
  localparam logic [2:0] PH_EXT        = 3'd3;
  localparam logic [2:0] PH_MASK       = 3'd4;
  localparam logic [2:0] PH_DATA       = 3'd5;

  logic [2:0]     phase_r, phase_nxt;
  logic [3:0]     opc_r, opc_nxt;
  logic           mask_r, mask_nxt;
  logic [3:0]     left_r, left_nxt;
  logic [LCB-1:0] len_r, len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [LCB-1:0] idx_r, idx_nxt;
  logic           halt_r, halt_nxt;

  logic [LCB+7:0] shifted;
  logic [LCB-1:0] cand_len;
  logic           cand_ovf;
  logic           cand_mask;
  logic           too_long;
  logic           is_last;
  logic [7:0]     key_byte;
  logic [6:0]     len7;

  assign len7     = byte_in[6:0];
  assign shifted  = {len_r, byte_in};
  assign is_last  = ({1'b0, idx_r} + {{LCB{1'b0}}, 1'b1}) >= {1'b0, len_r};

  always_comb begin
    if (phase_r == PH_EXT) begin
      cand_len  = shifted[LCB-1:0];
      cand_ovf  = ovf_r | (shifted[LCB+7:LCB] != 8'd0);
      cand_mask = mask_r;
    end else begin
      cand_len  = LCB'(len7);
      cand_ovf  = 1'b0;
      cand_mask = byte_in[7];
    end
    too_long = cand_ovf || (CW'(cand_len) > CW'(max_payload));
  end

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    left_nxt  = left_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    halt_nxt  = halt_r;
    res       = '0;
    res.frame_opcode = opc_r;

    if (step && !halt_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          opc_nxt   = byte_in[3:0];
          phase_nxt = byte_in[7] ? PH_HDR1 : PH_HDR1_NOFIN;
        end
        PH_HDR1_NOFIN: begin
          halt_nxt       = 1'b1;
          phase_nxt      = PH_HDR0;
          res.valid      = 1'b1;
          res.kind       = wsd_pkg::KIND_ERROR;
          res.error_code = wsd_pkg::ERR_NOT_FINAL;
        end
        PH_HDR1, PH_EXT: begin
          mask_nxt = cand_mask;
          len_nxt  = cand_len;
          ovf_nxt  = cand_ovf;
          if (phase_r == PH_EXT) begin
            left_nxt = left_r - 4'd1;
          end
          if (phase_r == PH_HDR1 && len7 == 7'd126) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            left_nxt  = 4'd2;
            phase_nxt = PH_EXT;
          end else if (phase_r == PH_HDR1 && len7 == 7'd127) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            left_nxt  = 4'd8;
            phase_nxt = PH_EXT;
          end else if (phase_r == PH_EXT && left_r != 4'd1) begin
            phase_nxt = PH_EXT;
          end else if (!cand_mask) begin
            halt_nxt       = 1'b1;
            phase_nxt      = PH_HDR0;
            res.valid      = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_NOT_MASKED;
          end else if (too_long) begin
            halt_nxt       = 1'b1;
            phase_nxt      = PH_HDR0;
            res.valid      = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_TOO_LONG;
          end else begin
            phase_nxt = PH_MASK;
            left_nxt  = 4'd4;
            key_nxt   = '0;
          end
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], byte_in};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            idx_nxt = '0;
            if (len_r == '0) begin
              phase_nxt = PH_HDR0;
              res.valid = 1'b1;
              res.kind  = wsd_pkg::KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res.valid     = 1'b1;
          res.kind      = wsd_pkg::KIND_DATA;
          res.data_byte = byte_in ^ key_byte;
          res.last      = is_last;
          idx_nxt       = idx_r + {{(LCB-1){1'b0}}, 1'b1};
          if (is_last) begin
            phase_nxt = PH_HDR0;
            idx_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      opc_r   <= '0;
      mask_r  <= 1'b0;
      left_r  <= '0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      key_r   <= '0;
      idx_r   <= '0;
      halt_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

// File: src/wsd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register; holds an item until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  wsd_pkg::res_t res,
  input  logic          out_ready,
  output logic          can_load,
  output logic          out_valid,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_data_byte,
  output logic [3:0]    out_frame_opcode,
  output logic          out_last,
  output logic [1:0]    out_error_code
);

  logic          valid_r, valid_nxt;
  wsd_pkg::res_t data_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = data_r.kind;
  assign out_data_byte    = data_r.data_byte;
  assign out_frame_opcode = data_r.frame_opcode;
  assign out_last         = data_r.last;
  assign out_error_code   = data_r.error_code;

endmodule

// File: src/wsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer result channel.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [3:0]  out_frame_opcode,
  input logic        out_last,
  input logic [1:0]  out_error_code
);

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == wsd_pkg::KIND_DATA || out_kind == wsd_pkg::KIND_EMPTY ||
                   out_kind == wsd_pkg::KIND_ERROR))
    else $error("bad result kind");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != wsd_pkg::KIND_DATA) |-> (out_data_byte == 8'd0))
    else $error("data byte not zero on non-data item");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == wsd_pkg::KIND_ERROR) ? !out_last
                   : (out_error_code == wsd_pkg::ERR_NOT_FINAL)))
    else $error("inconsistent last/error code");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_frame_opcode) && $stable(out_last) &&
      $stable(out_error_code)))
    else $error("result changed while stalled");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_data_byte    (out_data_byte),
  .out_frame_opcode (out_frame_opcode),
  .out_last         (out_last),
  .out_error_code   (out_error_code)
);

// File: sim/ws_deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws_deframe_checker
// Watches the byte, result and APB channels of the frame deframer, tracks
// the parser state for every accepted byte and compares each accepted
// result item field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module ws_deframe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [3:0]  out_frame_opcode,
  input  logic        out_last,
  input  logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    ST_HEAD0, ST_HEAD1, ST_NOFIN, ST_EXTLEN, ST_KEY, ST_PAYLOAD
  } parse_st_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] opcode;
    logic       last;
    logic [1:0] err;
  } frame_res_t;

  frame_res_t                        exp_q[$];
  parse_st_t                         st;
  logic [3:0]                        opcode;
  logic                              masked;
  logic [3:0]                        bytes_left;
  logic [63:0]                       frame_len;
  logic [31:0]                       key;
  logic [23:0]                       pay_idx;
  logic                              halted;
  logic [wsd_pkg::MAX_PAYLOAD_W-1:0] max_len;
  int                                mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] deframer mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic expect_res(input logic [1:0] kind, input logic [7:0] data,
                            input logic last, input logic [1:0] err);
    frame_res_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.opcode    = opcode;
    r.last      = last;
    r.err       = err;
    exp_q = {exp_q, r};
  endtask

  task automatic raise_error(input logic [1:0] err);
    halted = 1'b1;
    st     = ST_HEAD0;
    expect_res(wsd_pkg::KIND_ERROR, 8'h00, 1'b0, err);
  endtask

  // mask is checked before length; limit never exceeds the 24-bit counter
  task automatic length_known();
    if (!masked) begin
      raise_error(wsd_pkg::ERR_NOT_MASKED);
    end else if (frame_len > {40'd0, max_len}) begin
      raise_error(wsd_pkg::ERR_TOO_LONG);
    end else begin
      st         = ST_KEY;
      bytes_left = 4'd4;
      key        = '0;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [1:0] lane;
    logic [7:0] kb;
    logic       fin_byte;
    if (halted) return;
    case (st)
      ST_HEAD0: begin
        opcode = b[3:0];
        st     = b[7] ? ST_HEAD1 : ST_NOFIN;
      end
      ST_NOFIN: begin
        raise_error(wsd_pkg::ERR_NOT_FINAL);
      end
      ST_HEAD1: begin
        masked    = b[7];
        frame_len = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          bytes_left = 4'd2;
          st         = ST_EXTLEN;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          bytes_left = 4'd8;
          st         = ST_EXTLEN;
        end else begin
          frame_len = {57'd0, b[6:0]};
          length_known();
        end
      end
      ST_EXTLEN: begin
        frame_len  = {frame_len[55:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) length_known();
      end
      ST_KEY: begin
        key        = {key[23:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) begin
          pay_idx = '0;
          if (frame_len == 64'd0) begin
            st = ST_HEAD0;
            expect_res(wsd_pkg::KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
          end else begin
            st = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        lane     = pay_idx[1:0];
        kb       = key[8*(3-lane) +: 8];
        fin_byte = ({40'd0, pay_idx} + 64'd1) >= frame_len;
        pay_idx  = pay_idx + 24'd1;
        if (fin_byte) begin
          st      = ST_HEAD0;
          pay_idx = '0;
        end
        expect_res(wsd_pkg::KIND_DATA, b ^ kb, fin_byte, ERR_NONE);
      end
      default: begin
        st = ST_HEAD0;
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    frame_res_t want;
    if (!rst_n) begin
      st         = ST_HEAD0;
      opcode     = '0;
      masked     = 1'b0;
      bytes_left = '0;
      frame_len  = '0;
      key        = '0;
      pay_idx    = '0;
      halted     = 1'b0;
      max_len    = wsd_pkg::MAX_PAYLOAD_RST;
      exp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {wsd_pkg::REG_MAX_PAYLOAD, 2'b00})
        max_len = pwdata[wsd_pkg::MAX_PAYLOAD_W-1:0];
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result item, kind %0d", out_kind));
        end else begin
          want = exp_q.pop_front();
          check_field("kind", {6'd0, out_kind}, {6'd0, want.kind});
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("frame_opcode", {4'd0, out_frame_opcode}, {4'd0, want.opcode});
          check_field("last", {7'd0, out_last}, {7'd0, want.last});
          check_field("error_code", {6'd0, out_error_code}, {6'd0, want.err});
        end
      end
      if (in_valid && in_ready) deframe_byte(in_byte);
    end
    pending    <= exp_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: sim/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Feeds directed and random masked WebSocket frames through the deframer
// under several max_payload settings and handshake idling patterns, ends
// with one framing error and ignored trailing bytes, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;

  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned ITEMS_PER_STAGE = 150;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned TIMEOUT_NS      = 400000;
  localparam logic [6:0]  LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64  = 7'd127;

  typedef enum int {LEN7, LEN16, LEN64} len_enc_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [3:0]  out_frame_opcode;
  logic        out_last;
  logic [1:0]  out_error_code;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  bit          hold_request = 1'b0;
  logic [23:0] cur_max;

  always #1 clk = ~clk;

  websocket_frame_deframer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_last         (out_last),
    .out_error_code   (out_error_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  ws_deframe_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_last         (out_last),
    .out_error_code   (out_error_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  function automatic int unsigned cap_len(input int unsigned c);
    return (32'(cur_max) < c) ? 32'(cur_max) : c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_header(input bit fin, input bit masked, input logic [63:0] len,
                             input len_enc_t enc);
    logic [7:0] hdr;
    hdr    = 8'($urandom_range(255, 0));
    hdr[7] = fin;
    send_byte(hdr);
    case (enc)
      LEN7: begin
        send_byte({masked, len[6:0]});
      end
      LEN16: begin
        send_byte({masked, LEN_CODE_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic tx_frame(input int unsigned len, input len_enc_t enc);
    logic [31:0] mkey;
    mkey = $urandom;
    send_header(1'b1, 1'b1, 64'(len), enc);
    for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [23:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {wsd_pkg::REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= {8'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = v;
  endtask

  // receiver: random backpressure, plus one long hold on request
  initial begin : result_sink
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned len;
    len_enc_t    enc;
    logic [63:0] big;
    bit          held_once;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    held_once = 1'b0;
    cur_max   = wsd_pkg::MAX_PAYLOAD_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame, opcode 15, all-ones key
    send_byte(8'h8F); send_byte(8'h80);
    repeat (4) send_byte(8'hFF);
    // RSV bits set, opcode 0, 16-bit length of 2
    send_byte(8'hF0); send_byte(8'hFE); send_byte(8'h00); send_byte(8'h02);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'h00);
    // 5 bytes: key lanes wrap
    send_byte(8'h81); send_byte(8'h85);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
    send_byte(8'hAA); send_byte(8'h55); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h3C);

    items_sent = 0;
    for (int stage = 0; stage < 4; stage++) begin
      wait_drained();
      case (stage)
        0: write_max_payload(24'hFFFFFF);
        1: write_max_payload(24'd0);
        2: write_max_payload(24'($urandom_range(40, 1)));
        default: write_max_payload(24'($urandom_range(300, 41)));
      endcase
      while (items_sent < (stage + 1) * ITEMS_PER_STAGE) begin
        if (items_sent < 200) begin
          send_idle_pct = 33;
          recv_idle_pct = 76;
        end else if (items_sent < 400) begin
          send_idle_pct = 76;
          recv_idle_pct = 33;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (stage == 3 && !held_once) begin
          held_once    = 1'b1;
          hold_request = 1'b1;
          tx_frame(40, LEN7);
          continue;
        end
        r = $urandom_range(99, 0);
        if (r < 5 && cur_max >= 125) begin
          len = 125;
          enc = LEN7;
        end else if (r < 12) begin
          len = cap_len(200);
          enc = (len > 125) ? LEN16 : LEN7;
        end else if (r < 75) begin
          len = $urandom_range(cap_len(20), 0);
          enc = LEN7;
        end else if (r < 90) begin
          len = $urandom_range(cap_len(200), 0);
          enc = LEN16;
        end else begin
          len = $urandom_range(cap_len(40), 0);
          enc = LEN64;
        end
        tx_frame(len, enc);
      end
    end

    // one framing error, then bytes that must be dropped
    wait_drained();
    send_idle_pct = 0;
    big = {$urandom, $urandom};
    if (big <= {40'd0, cur_max}) big = {40'd0, cur_max} + 64'd1;
    case ($urandom_range(3, 0))
      0: send_header(1'b0, 1'b1, 64'($urandom_range(125, 0)), LEN7);
      1: send_header(1'b1, 1'b0, 64'($urandom_range(125, 0)), LEN7);
      2: begin
        if (cur_max < 125 && $urandom_range(1, 0) == 0)
          send_header(1'b1, 1'b1, 64'($urandom_range(125, 32'(cur_max) + 1)), LEN7);
        else
          send_header(1'b1, 1'b1, big, LEN64);
      end
      default: send_header(1'b1, 1'b0, big, LEN64);
    endcase
    repeat (12) send_byte(8'($urandom_range(255, 0)));
    wait_drained();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/wsd_pkg.sv
src/wsd_cfg_regs.sv
src/wsd_parser.sv
src/wsd_out_stage.sv
src/websocket_frame_deframer_unit.sv
src/wsd_checker.sv
sim/ws_deframe_checker.sv
sim/tb_websocket_frame_deframer_unit.sv
